// ===== rtl/core/pdp_pkg.sv =====
// Package for the panel dipole potential block.
// Widths, job and state types, and the CORDIC angle table.
// No dependencies.
package pdp_pkg;

  localparam int COORD_W   = 32;
  localparam int R_W       = COORD_W - 1;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int WIDE_W    = 100;
  localparam int NORM_BITS = 30;
  localparam int CSTEPS    = 28;
  localparam int CW        = 34;
  localparam int ZW        = 33;
  localparam int ANG_Q     = 30;
  localparam int OUT_FRAC  = 16;
  localparam int PHI_W     = 24;
  localparam int CNT_W     = 4;
  localparam int NODE_MIN  = 3;
  localparam int NODE_MAX  = 8;
  localparam int NODE_RST  = 4;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int SER_STEPS = 32;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  typedef struct packed {
    logic [R_W-1:0]            r;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic signed [COORD_W-1:0] dz;
  } node_t;

  typedef struct packed {
    node_t                     node;
    logic signed [COORD_W-1:0] dxi;
    logic signed [COORD_W-1:0] deta;
    logic                      neg;
    logic                      last;
  } job_t;

  typedef enum logic {F_IDLE, F_EMIT} front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_PROD, B_SER, B_DIFF, B_SIGN, B_NORM, B_CORD, B_ACC
  } back_state_t;

  typedef enum logic [1:0] {J_PREV, J_CUR_PREV, J_CUR, J_FIRST} job_sel_t;

  function automatic logic [31:0] cordic_atan(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      5'd24: v = 32'd64;
      5'd25: v = 32'd32;
      5'd26: v = 32'd16;
      5'd27: v = 32'd8;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/pdp_if.sv =====
// Channel interfaces of the panel dipole potential block.
// Depends on pdp_pkg.
interface pdp_node_if;
  import pdp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [R_W-1:0]            node_distance;
  logic signed [COORD_W-1:0] offset_x;
  logic signed [COORD_W-1:0] offset_y;
  logic signed [COORD_W-1:0] offset_z;
  logic signed [COORD_W-1:0] edge_dxi;
  logic signed [COORD_W-1:0] edge_deta;
  modport source(output valid, node_distance, offset_x, offset_y, offset_z,
                 edge_dxi, edge_deta, input ready);
  modport sink(input valid, node_distance, offset_x, offset_y, offset_z,
               edge_dxi, edge_deta, output ready);
endinterface

interface pdp_result_if;
  import pdp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [PHI_W-1:0] phi_sum;
  logic                    degenerate;
  modport source(output valid, phi_sum, degenerate, input ready);
  modport sink(input valid, phi_sum, degenerate, output ready);
endinterface

interface pdp_cfg_if;
  import pdp_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] node_count;
  modport source(output valid, node_count, input ready);
  modport sink(input valid, node_count, output ready);
endinterface

// ===== rtl/core/pdp_front.sv =====
// Front end: accepts panel nodes, keeps first and previous node,
// and issues edge angle jobs. Depends on pdp_pkg and pdp_if.
module pdp_front (
  input  logic                         clk,
  input  logic                         rst,
  pdp_node_if.sink                     node_in,
  input  logic [pdp_pkg::CNT_W-1:0]    node_count,
  output pdp_pkg::job_t                job,
  output logic                         job_valid,
  input  logic                         job_ready
);
  import pdp_pkg::*;

  front_state_t              state, state_next;
  logic [CNT_W-1:0]          node_index;
  node_t                     first, prev_node, cur;
  logic signed [COORD_W-1:0] prev_dxi, prev_deta, cur_dxi, cur_deta;
  job_sel_t                  jsel;
  job_sel_t                  jend;
  logic [CNT_W-1:0]          n_eff;
  logic                      closing;
  logic                      accept;
  logic                      emit_done;

  always_comb begin
    if (node_count < CNT_W'(NODE_MIN)) n_eff = CNT_W'(NODE_MIN);
    else if (node_count > CNT_W'(NODE_MAX)) n_eff = CNT_W'(NODE_MAX);
    else n_eff = node_count;
  end

  assign closing   = ({1'b0, node_index} + 5'd1) >= {1'b0, n_eff};
  assign accept    = node_in.valid && node_in.ready;
  assign emit_done = job_valid && job_ready && (jsel == jend);

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (accept && (node_index != '0)) state_next = F_EMIT;
      F_EMIT: if (emit_done) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    node_in.ready = 1'b0;
    job_valid     = 1'b0;
    unique case (state)
      F_IDLE: node_in.ready = 1'b1;
      F_EMIT: job_valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    job.neg  = 1'b0;
    job.last = 1'b0;
    job.node = cur;
    job.dxi  = prev_dxi;
    job.deta = prev_deta;
    case (jsel)
      J_PREV:     job.node = prev_node;
      J_CUR_PREV: job.neg = 1'b1;
      J_CUR: begin
        job.dxi  = cur_dxi;
        job.deta = cur_deta;
      end
      J_FIRST: begin
        job.node = first;
        job.dxi  = cur_dxi;
        job.deta = cur_deta;
        job.neg  = 1'b1;
        job.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      node_index <= '0;
      jsel       <= J_PREV;
      jend       <= J_CUR_PREV;
    end else begin
      state <= state_next;
      if (accept) begin
        node_index <= closing ? '0 : node_index + 1'b1;
        jsel       <= J_PREV;
        jend       <= closing ? J_FIRST : J_CUR_PREV;
      end else if (job_valid && job_ready && !emit_done) begin
        jsel <= job_sel_t'(jsel + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur.r    <= node_in.node_distance;
      cur.dx   <= node_in.offset_x;
      cur.dy   <= node_in.offset_y;
      cur.dz   <= node_in.offset_z;
      cur_dxi  <= node_in.edge_dxi;
      cur_deta <= node_in.edge_deta;
      if (node_index == '0) begin
        first.r      <= node_in.node_distance;
        first.dx     <= node_in.offset_x;
        first.dy     <= node_in.offset_y;
        first.dz     <= node_in.offset_z;
        prev_node.r  <= node_in.node_distance;
        prev_node.dx <= node_in.offset_x;
        prev_node.dy <= node_in.offset_y;
        prev_node.dz <= node_in.offset_z;
        prev_dxi     <= node_in.edge_dxi;
        prev_deta    <= node_in.edge_deta;
      end
    end else if (emit_done) begin
      prev_node <= cur;
      prev_dxi  <= cur_dxi;
      prev_deta <= cur_deta;
    end
  end

endmodule

// ===== rtl/core/pdp_queue.sv =====
// Short job queue between front and back end.
// Depends on pdp_pkg.
module pdp_queue (
  input  logic          clk,
  input  logic          rst,
  input  pdp_pkg::job_t push_job,
  input  logic          push_valid,
  output logic          push_ready,
  output pdp_pkg::job_t pop_job,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import pdp_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push, pop;

  assign push_ready = count != (QPTR_W+1)'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count beyond depth");
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !pop)
    else $error("pop from empty queue");
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (count == (QPTR_W+1)'(QDEPTH) && !pop) |=> (count == (QPTR_W+1)'(QDEPTH)))
    else $error("full queue lost an entry");

endmodule

// ===== rtl/core/pdp_back.sv =====
// Back end: forms N and D with one shared multiplier and serial adders,
// normalizes, runs CORDIC vectoring and accumulates. Depends on pdp_pkg, pdp_if.
module pdp_back (
  input  logic          clk,
  input  logic          rst,
  input  pdp_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_ready,
  pdp_result_if.source  result_out
);
  import pdp_pkg::*;

  back_state_t               state, state_next;
  job_t                      jb;
  logic [4:0]                cnt;
  logic signed [COORD_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [WIDE_W-1:0]  sq, tq, uq, na1, na2, da;
  logic [COORD_W-1:0]        ms1, ms2, ms3;
  logic [WIDE_W-1:0]         xm, ym, both, num_mag, den_mag;
  logic                      yneg, num_neg, den_neg;
  logic signed [CW-1:0]      cx, cy, xs, ys;
  logic signed [ZW-1:0]      z, tab, zr;
  logic signed [PHI_W-1:0]   ang, acc, acc_next;
  logic                      deg_seen;
  logic                      out_free;
  logic                      norm_done;

  assign job_ready = (state == B_IDLE);
  assign out_free  = !result_out.valid || result_out.ready;
  assign prod      = mul_a * mul_b;

  always_comb begin
    mul_a = jb.node.dx;
    mul_b = jb.node.dx;
    case (cnt[1:0])
      2'd1: begin
        mul_a = jb.node.dz;
        mul_b = jb.node.dz;
      end
      2'd2: mul_b = jb.node.dy;
      2'd3: begin
        mul_a = jb.node.dz;
        mul_b = jb.dxi;
      end
      default: ;
    endcase
  end

  assign num_neg = na1[WIDE_W-1];
  assign den_neg = da[WIDE_W-1];
  assign num_mag = num_neg ? WIDE_W'(-na1) : na1;
  assign den_mag = den_neg ? WIDE_W'(-da) : da;

  assign both      = xm | ym;
  assign norm_done = (both[WIDE_W-1:NORM_BITS] == '0) && both[NORM_BITS-1];

  assign xs  = cx >>> cnt;
  assign ys  = cy >>> cnt;
  assign tab = {1'b0, cordic_atan(cnt)};
  assign zr  = z + ZW'(1 << (ANG_Q - OUT_FRAC - 1));
  assign ang = PHI_W'(zr >>> (ANG_Q - OUT_FRAC));
  assign acc_next = jb.neg ? acc - ang : acc + ang;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (job_valid) state_next = B_PROD;
      B_PROD: if (cnt == 5'd3) state_next = B_SER;
      B_SER:  if (cnt == 5'(SER_STEPS - 1)) state_next = B_DIFF;
      B_DIFF: state_next = B_SIGN;
      B_SIGN: state_next = (da == '0) ? B_ACC : B_NORM;
      B_NORM: if (norm_done) state_next = B_CORD;
      B_CORD: if (cnt == 5'(CSTEPS - 1)) state_next = B_ACC;
      B_ACC:  if (!jb.last || out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= B_IDLE;
      acc               <= '0;
      deg_seen          <= 1'b0;
      result_out.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (result_out.valid && result_out.ready) result_out.valid <= 1'b0;
      if (state == B_SIGN && da == '0 && na1 == '0) deg_seen <= 1'b1;
      if (state == B_ACC && (!jb.last || out_free)) begin
        if (jb.last) begin
          result_out.valid <= 1'b1;
          acc              <= '0;
          deg_seen         <= 1'b0;
        end else begin
          acc <= acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt + 1'b1;
    unique case (state)
      B_IDLE: begin
        cnt <= '0;
        if (job_valid) jb <= job;
      end
      B_PROD: begin
        case (cnt[1:0])
          2'd0: sq <= {{(WIDE_W-PROD_W){prod[PROD_W-1]}}, prod};
          2'd1: sq <= sq + {{(WIDE_W-PROD_W){prod[PROD_W-1]}}, prod};
          2'd2: tq <= {{(WIDE_W-PROD_W){prod[PROD_W-1]}}, prod};
          default: uq <= {{(WIDE_W-PROD_W){prod[PROD_W-1]}}, prod};
        endcase
        na1 <= '0;
        na2 <= '0;
        da  <= '0;
        ms1 <= jb.deta;
        ms2 <= jb.dxi;
        ms3 <= {1'b0, jb.node.r};
        if (cnt == 5'd3) cnt <= '0;
      end
      B_SER: begin
        if (ms1[0]) na1 <= (cnt == 5'(SER_STEPS - 1)) ? na1 - sq : na1 + sq;
        if (ms2[0]) na2 <= (cnt == 5'(SER_STEPS - 1)) ? na2 - tq : na2 + tq;
        if (ms3[0]) da <= da + uq;
        sq  <= sq <<< 1;
        tq  <= tq <<< 1;
        uq  <= uq <<< 1;
        ms1 <= ms1 >> 1;
        ms2 <= ms2 >> 1;
        ms3 <= ms3 >> 1;
      end
      B_DIFF: na1 <= na1 - na2;
      B_SIGN: begin
        xm   <= den_mag;
        ym   <= num_mag;
        yneg <= num_neg ^ den_neg;
        if (da == '0) begin
          if (na1 == '0) z <= '0;
          else if (num_neg) z <= -ZW'(HALF_PI_Q30);
          else z <= ZW'(HALF_PI_Q30);
        end
      end
      B_NORM: begin
        cnt <= '0;
        if (both[WIDE_W-1:NORM_BITS+8] != '0) begin
          xm <= xm >> 8;
          ym <= ym >> 8;
        end else if (both[WIDE_W-1:NORM_BITS] != '0) begin
          xm <= xm >> 1;
          ym <= ym >> 1;
        end else if (both[NORM_BITS-1:NORM_BITS-8] == '0) begin
          xm <= xm << 8;
          ym <= ym << 8;
        end else if (!both[NORM_BITS-1]) begin
          xm <= xm << 1;
          ym <= ym << 1;
        end else begin
          cx <= CW'(xm[NORM_BITS-1:0]);
          cy <= yneg ? -CW'(ym[NORM_BITS-1:0]) : CW'(ym[NORM_BITS-1:0]);
          z  <= '0;
        end
      end
      B_CORD: begin
        if (!cy[CW-1]) begin
          cx <= cx + ys;
          cy <= cy - xs;
          z  <= z + tab;
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          z  <= z - tab;
        end
      end
      B_ACC: begin
        if (jb.last && out_free) begin
          result_out.phi_sum    <= acc_next;
          result_out.degenerate <= deg_seen;
        end
      end
      default: ;
    endcase
  end

  a_cordic_x_pos: assert property (@(posedge clk) disable iff (rst)
    (state == B_CORD) |-> !cx[CW-1])
    else $error("cordic x went negative");
  a_cordic_len: assert property (@(posedge clk) disable iff (rst)
    (state == B_CORD) |-> (cnt < 5'(CSTEPS)))
    else $error("cordic step count overrun");
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == B_ACC && jb.last && out_free) |=> result_out.valid)
    else $error("panel result not presented");

endmodule

// ===== rtl/core/panel_dipole_potential.sv =====
// Top level of the panel dipole potential block: config register, front end,
// job queue and back end. Depends on pdp_pkg, pdp_if, pdp_front, pdp_queue, pdp_back.
//
// Usage:
//   node_in    : one panel node per item (distance, offsets, edge deltas).
//   result_out : one item per panel (phi_sum Q7.16, degenerate flag), after
//                the node whose position reaches node_count (clamped 3..8).
//   cfg        : writes node_count; always ready. Write only while idle.
// Flow:
//   Each edge term is one back-end job: issue, multiplier products,
//   32 serial add steps, difference and sign, normalize, 28 CORDIC steps
//   and accumulate; a zero denominator skips normalize and CORDIC.
//   The first node of a panel brings no job, a middle node two, the closing
//   node four; the sum follows the closing node's last job. The front end
//   emits a node's jobs into a 4-entry queue and then takes the next node,
//   so input and back end overlap by up to one node.
// Reset: node_count returns to 4, panel sum, node index and flag clear.
// Stall: a held result blocks only the closing job of the next panel.
module panel_dipole_potential (
  input  logic          clk,
  input  logic          rst,
  pdp_node_if.sink      node_in,
  pdp_result_if.source  result_out,
  pdp_cfg_if.sink       cfg
);
  import pdp_pkg::*;

  logic [CNT_W-1:0] node_count;
  job_t             fq_job, qb_job;
  logic             fq_valid, fq_ready, qb_valid, qb_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) node_count <= CNT_W'(NODE_RST);
    else if (cfg.valid && cfg.ready) node_count <= cfg.node_count;
  end

  pdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .node_in    (node_in),
    .node_count (node_count),
    .job        (fq_job),
    .job_valid  (fq_valid),
    .job_ready  (fq_ready)
  );

  pdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (fq_job),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .pop_job    (qb_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready)
  );

  pdp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job        (qb_job),
    .job_valid  (qb_valid),
    .job_ready  (qb_ready),
    .result_out (result_out)
  );

endmodule

// ===== verif/pdp_checker.sv =====
`timescale 1ns / 1ps
// Checker for panel_dipole_potential: watches the node, result and config channels,
// predicts each panel sum with exact wide arithmetic and a CORDIC atan2, and compares.
// Depends on pdp_pkg and pdp_if.
module pdp_checker (
  input  logic  clk,
  input  logic  rst,
  pdp_node_if   node_mon,
  pdp_result_if res_mon,
  pdp_cfg_if    cfg_mon,
  output int    errors,
  output int    pending,
  output int    panels,
  output int    degen_panels
);
  import pdp_pkg::*;

  typedef struct {
    logic signed [PHI_W-1:0] phi;
    logic                    degen;
  } panel_sum_t;

  typedef struct {
    logic [R_W-1:0]            r;
    logic signed [COORD_W-1:0] dx, dy, dz, dxi, deta;
  } node_rec_t;

  localparam longint ATAN_Q30 [28] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8};
  localparam longint HALF_PI = 1686629713;

  panel_sum_t      sums_due[$];
  logic [CNT_W-1:0] count_reg;
  node_rec_t       first_rec, prev_rec;
  int              angle_acc;
  int              node_pos;
  bit              degen_seen;

  function automatic int to_q16(longint z);
    return int'((z + (64'sd1 <<< 13)) >>> 14);
  endfunction

  function automatic int edge_atan(logic [R_W-1:0] r, logic signed [COORD_W-1:0] dx, dy, dz,
                                   logic signed [COORD_W-1:0] dxi, deta);
    logic signed [191:0] wr, wdx, wdy, wdz, wxi, weta, num, den;
    logic [191:0] ymag, both, xs_w, ys_w;
    int len;
    bit yneg;
    longint x, y, z, xs, ys;
    wr = {161'b0, r};
    wdx = dx; wdy = dy; wdz = dz; wxi = dxi; weta = deta;
    num = weta * (wdx * wdx + wdz * wdz) - wxi * (wdx * wdy);
    den = wr * (wdz * wxi);
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (den == 0) begin
      if (num == 0) begin
        degen_seen = 1'b1;
        return 0;
      end
      return to_q16(num < 0 ? -HALF_PI : HALF_PI);
    end
    yneg = num < 0;
    ymag = yneg ? -num : num;
    both = ymag | den;
    len = 0;
    for (int k = 0; k < 192; k++) if (both[k]) len = k + 1;
    if (len > NORM_BITS) begin
      xs_w = den >> (len - NORM_BITS);
      ys_w = ymag >> (len - NORM_BITS);
    end else begin
      xs_w = den << (NORM_BITS - len);
      ys_w = ymag << (NORM_BITS - len);
    end
    x = longint'(xs_w[63:0]);
    y = yneg ? -longint'(ys_w[63:0]) : longint'(ys_w[63:0]);
    z = 0;
    for (int k = 0; k < 28; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_Q30[k];
      end else begin
        x -= ys; y += xs; z -= ATAN_Q30[k];
      end
    end
    return to_q16(z);
  endfunction

  task automatic absorb_node(node_rec_t cur);
    int n;
    panel_sum_t s;
    n = count_reg;
    if (n < NODE_MIN) n = NODE_MIN;
    if (n > NODE_MAX) n = NODE_MAX;
    if (node_pos == 0) begin
      first_rec = cur;
    end else begin
      angle_acc += edge_atan(prev_rec.r, prev_rec.dx, prev_rec.dy, prev_rec.dz,
                             prev_rec.dxi, prev_rec.deta)
                 - edge_atan(cur.r, cur.dx, cur.dy, cur.dz, prev_rec.dxi, prev_rec.deta);
    end
    prev_rec = cur;
    node_pos++;
    if (node_pos >= n) begin
      angle_acc += edge_atan(cur.r, cur.dx, cur.dy, cur.dz, cur.dxi, cur.deta)
                 - edge_atan(first_rec.r, first_rec.dx, first_rec.dy, first_rec.dz,
                             cur.dxi, cur.deta);
      s.phi = angle_acc[PHI_W-1:0];
      s.degen = degen_seen;
      sums_due.push_back(s);
      angle_acc = 0;
      degen_seen = 1'b0;
      node_pos = 0;
    end
  endtask

  task automatic report(string what, longint want, longint got);
    $display("[%0t] mismatch %s: expected %0d got %0d", $realtime, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    panel_sum_t s;
    node_rec_t cur;
    if (rst) begin
      count_reg = CNT_W'(NODE_RST);
      angle_acc = 0;
      node_pos = 0;
      degen_seen = 1'b0;
      sums_due.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (sums_due.size() == 0) begin
          report("unexpected result, phi_sum", 0, res_mon.phi_sum);
        end else begin
          s = sums_due.pop_front();
          panels++;
          if (s.degen) degen_panels++;
          if (res_mon.phi_sum !== s.phi) report("phi_sum", s.phi, res_mon.phi_sum);
          if (res_mon.degenerate !== s.degen)
            report("degenerate", s.degen, res_mon.degenerate);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) count_reg = cfg_mon.node_count;
      if (node_mon.valid && node_mon.ready) begin
        cur.r = node_mon.node_distance;
        cur.dx = node_mon.offset_x;
        cur.dy = node_mon.offset_y;
        cur.dz = node_mon.offset_z;
        cur.dxi = node_mon.edge_dxi;
        cur.deta = node_mon.edge_deta;
        absorb_node(cur);
      end
    end
    pending = sums_due.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    panels = 0;
    degen_panels = 0;
  end
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Top of the panel_dipole_potential testbench: clock, reset, node and config stimulus,
// random idling on both channels, and the verdict. Depends on pdp_pkg, pdp_if, pdp_checker.
module testbench;
  import pdp_pkg::*;

  localparam int SETTLE = 600;
  localparam int LIMIT  = 3000000;

  logic clk;
  logic rst;
  int   errors, pending, panels, degen_panels;
  int   send_idle, recv_idle, hold_cycles, cycles, items_sent;

  pdp_node_if   node_ch ();
  pdp_result_if res_ch ();
  pdp_cfg_if    cfg_ch ();

  panel_dipole_potential dut (
    .clk(clk), .rst(rst), .node_in(node_ch.sink), .result_out(res_ch.source), .cfg(cfg_ch.sink)
  );

  pdp_checker chk (
    .clk(clk), .rst(rst), .node_mon(node_ch), .res_mon(res_ch), .cfg_mon(cfg_ch),
    .errors(errors), .pending(pending), .panels(panels), .degen_panels(degen_panels)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: long hold-off, else random stall
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'sd0;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      3, 4: return $urandom_range(2 * 65536 * 16) - 65536 * 16;
      5, 6: return $urandom_range(2 * 65536 * 256) - 65536 * 256;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [R_W-1:0] pick_dist();
    case ($urandom_range(7))
      0: return '0;
      1: return {R_W{1'b1}};
      2, 3: return R_W'($urandom_range(65536 * 64));
      default: return R_W'($urandom());
    endcase
  endfunction

  task automatic send_node(logic [R_W-1:0] r, logic signed [31:0] dx, dy, dz, dxi, deta);
    while ($urandom_range(99) < send_idle) begin
      node_ch.valid <= 1'b0;
      @(negedge clk);
    end
    node_ch.valid <= 1'b1;
    node_ch.node_distance <= r;
    node_ch.offset_x <= dx;
    node_ch.offset_y <= dy;
    node_ch.offset_z <= dz;
    node_ch.edge_dxi <= dxi;
    node_ch.edge_deta <= deta;
    @(posedge clk);
    while (!node_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random();
    send_node(pick_dist(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
              pick_coord());
  endtask

  task automatic drain();
    node_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.node_count <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  logic [CNT_W-1:0] counts [8] = '{4'd3, 4'd8, 4'd0, 4'd15, 4'd5, 4'd1, 4'd6, 4'd7};

  initial begin
    rst = 1'b1;
    cycles = 0;
    items_sent = 0;
    hold_cycles = 0;
    send_idle = 13;
    recv_idle = 53;
    node_ch.valid = 1'b0;
    node_ch.node_distance = '0;
    node_ch.offset_x = '0;
    node_ch.offset_y = '0;
    node_ch.offset_z = '0;
    node_ch.edge_dxi = '0;
    node_ch.edge_deta = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.node_count = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset node count of 4
    send_node('0, 0, 0, 0, 0, 0);                          // zero over zero
    send_node({R_W{1'b1}}, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000, 32'sh7fffffff);
    send_node(65536, 65536, 0, 0, 65536, 65536);           // zero denominator, dz = 0
    send_node(65536, 65536, 65536, 65536, 0, -65536);      // zero dxi
    send_node({R_W{1'b1}}, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 32'sh80000000);
    send_node(1, -1, -1, -1, -1, -1);
    send_node(0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_node(131072, -65536, 65536, -65536, 65536, 0);    // zero deta
    for (int k = 0; k < 16; k++) begin
      send_node(R_W'(32'h1 << (k * 2)), 32'sh1 <<< (k * 2), -(32'sh1 <<< k),
                32'sh55555555 ^ (k << 20), 32'shaaaaaaaa >>> k, 32'sh1 <<< (31 - k));
    end
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle = 53;
        recv_idle = 13;
      end else if (p == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_count(counts[p]);
      if (p == 2) hold_cycles = 4000;
      for (int i = 0; i < 85; i++) begin
        if (p == 4 && i == 40) begin
          node_ch.valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
        send_random();
      end
      drain();
    end
    write_count(4'd4);
    for (int i = 0; i < 12; i++) send_random();
    drain();

    $display("%0d nodes sent, %0d panel sums checked, %0d flagged degenerate",
             items_sent, panels, degen_panels);
    $display("node counts 3..8 with out-of-range writes, stalls on both sides");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
